// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Concurrent assertion on the block clock and reset.
`define ASSERT_DEF(label, prop) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ===== rtl/core/sidc_pkg.sv =====
// Types and constants for the signed integer to decimal ASCII converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sidc_pkg;

  localparam int INPUT_WIDTH = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int CHAR_WIDTH  = 6;

  // Decimal digits needed for a magnitude of VALUE_WIDTH bits.
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_WIDTH   = NUM_DIGITS * 4;
  localparam int STEP_CNT_W  = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = CHAR_WIDTH'(48);
  localparam logic [CHAR_WIDTH-1:0] ASCII_NINE  = CHAR_WIDTH'(57);
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = CHAR_WIDTH'(45);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_ALIGN,
    S_SIGN,
    S_DIGIT
  } state_e;

  typedef struct packed {
    logic start;
    logic shift_digit;
  } conv_ctrl_t;

  typedef struct packed {
    logic       busy;
    logic [3:0] top_digit;
  } conv_stat_t;

endpackage

// ===== rtl/core/sidc_bin2bcd.sv =====
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
// Also shifts the digit register left by one digit on request. Uses sidc_pkg.
`timescale 1ns / 1ps

module sidc_bin2bcd (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sidc_pkg::conv_ctrl_t            ctrl_i,
  input  logic [sidc_pkg::VALUE_WIDTH-1:0] mag_i,
  output sidc_pkg::conv_stat_t            stat_o
);
  import sidc_pkg::*;

  logic [STEP_CNT_W-1:0]  cnt_q, cnt_d;
  logic [BCD_WIDTH-1:0]   bcd_q, bcd_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_WIDTH-1:0]   adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    bcd_d = bcd_q;
    mag_d = mag_q;
    if (ctrl_i.start) begin
      cnt_d = STEP_CNT_W'(VALUE_WIDTH);
      bcd_d = '0;
      mag_d = mag_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - STEP_CNT_W'(1);
      bcd_d = {adj[BCD_WIDTH-2:0], mag_q[VALUE_WIDTH-1]};
      mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
    end else if (ctrl_i.shift_digit) begin
      bcd_d = {bcd_q[BCD_WIDTH-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    mag_q <= mag_d;
  end

  assign stat_o.busy      = (cnt_q != '0);
  assign stat_o.top_digit = bcd_q[BCD_WIDTH-1 -: 4];

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii.sv =====
// After a request is taken, the BCD unit converts the magnitude, leading zero digits are
// shifted out, then the minus sign (when negative) and the digits are sent. A new request
// is taken only in idle; the BCD unit runs 32 shift-and-add-3 steps per conversion.
// Reset: asynchronous, active low; returns the sequencer to idle, no output pending.
// Top level of the converter; uses sidc_pkg and sidc_bin2bcd.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [sidc_pkg::INPUT_WIDTH-1:0] value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [sidc_pkg::CHAR_WIDTH-1:0]       char_code_o,
  output logic                                  last_o
);
  import sidc_pkg::*;

  state_e                 state_q, state_d;
  logic                   neg_q, neg_d;
  logic [DIG_CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] val_low;
  logic [VALUE_WIDTH-1:0] mag;
  conv_ctrl_t             ctrl;
  conv_stat_t             stat;
  logic                   in_acc;
  logic                   out_acc;
  logic                   more_digits;

  assign val_low     = value_i[VALUE_WIDTH-1:0];
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign more_digits = (cnt_q > DIG_CNT_W'(1));

  always_comb begin
    if (val_low[VALUE_WIDTH-1]) begin
      mag = ~val_low + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      mag = val_low;
    end
  end

  sidc_bin2bcd u_bin2bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .mag_i  (mag),
    .stat_o (stat)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CONV;
      end
      S_CONV: begin
        if (!stat.busy) state_d = S_ALIGN;
      end
      S_ALIGN: begin
        if (!(stat.top_digit == 4'd0 && more_digits)) begin
          state_d = neg_q ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_acc) state_d = S_DIGIT;
      end
      S_DIGIT: begin
        if (out_acc && !more_digits) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = 1'b1;
    out_valid_o      = 1'b0;
    char_code_o      = ASCII_MINUS;
    last_o           = 1'b0;
    ctrl.start       = 1'b0;
    ctrl.shift_digit = 1'b0;
    neg_d            = neg_q;
    cnt_d            = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        ctrl.start = in_valid_i;
        if (in_valid_i) begin
          neg_d = val_low[VALUE_WIDTH-1];
          cnt_d = DIG_CNT_W'(NUM_DIGITS);
        end
      end
      S_CONV: begin
      end
      S_ALIGN: begin
        if (stat.top_digit == 4'd0 && more_digits) begin
          ctrl.shift_digit = 1'b1;
          cnt_d            = cnt_q - DIG_CNT_W'(1);
        end
      end
      S_SIGN: begin
        out_valid_o = 1'b1;
      end
      S_DIGIT: begin
        out_valid_o = 1'b1;
        char_code_o = ASCII_ZERO + {{(CHAR_WIDTH-4){1'b0}}, stat.top_digit};
        last_o      = !more_digits;
        if (out_acc && more_digits) begin
          ctrl.shift_digit = 1'b1;
          cnt_d            = cnt_q - DIG_CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/sidc_checker.sv =====
// Port-level checks for the signed integer to decimal ASCII converter.
// Uses sidc_pkg and assert_macros.svh; bound to the top level below.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sidc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [sidc_pkg::CHAR_WIDTH-1:0] char_code_o,
  input logic                            last_o
);
  import sidc_pkg::*;

  logic in_take;
  logic out_take;
  logic char_ok;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;
  assign char_ok  = (char_code_o == ASCII_MINUS && !last_o) ||
                    (char_code_o >= ASCII_ZERO && char_code_o <= ASCII_NINE);

  `ASSERT_DEF(a_no_request_while_sending, out_valid_o |-> in_stall_o)
  `ASSERT_DEF(a_request_starts_conversion, in_take |=> (in_stall_o && !out_valid_o))
  `ASSERT_DEF(a_run_ends_after_last, (out_take && last_o) |=> !out_valid_o)
  `ASSERT_DEF(a_stalled_char_holds, (out_valid_o && out_stall_i) |=> $stable(char_code_o))
  `ASSERT_DEF(a_char_in_range, out_valid_o |-> char_ok)

endmodule

bind signed_int_to_decimal_ascii sidc_checker u_sidc_checker (.*);

// ===== sim/signed_int_to_decimal_ascii_tb.sv =====
// Self-checking testbench for signed_int_to_decimal_ascii: random and directed integers in,
// predicted ASCII text compared character by character. Depends on sidc_pkg and the block.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
  import sidc_pkg::*;

  localparam int GAP_MAX      = 13;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 250;
  localparam int QUIET_ITEMS  = 40;
  localparam int TOTAL_ITEMS  = 470;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 60;

  typedef struct {
    logic signed [INPUT_WIDTH-1:0] value;
    bit                            drain_first;
    bit                            quiet;
  } number_req_t;

  typedef struct {
    logic [CHAR_WIDTH-1:0] code;
    logic                  last;
  } text_char_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [INPUT_WIDTH-1:0] value_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [CHAR_WIDTH-1:0]         char_code_o;
  logic                          last_o;

  number_req_t number_q[$];
  text_char_t  expected_chars[$];
  int          fail_count = 0;
  int          requests_taken = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  int          sender_noise = 2;
  int          burst_left = 0;
  int          receiver_noise = 2;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  bit          tail_phase = 1'b0;

  signed_int_to_decimal_ascii uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void predict_text(logic signed [INPUT_WIDTH-1:0] value);
    logic [VALUE_WIDTH-1:0] bits;
    logic [VALUE_WIDTH-1:0] magnitude;
    longint unsigned        rest;
    int                     digit[24];
    int                     count;
    bit                     negative;
    text_char_t             ch;
    bits      = value[VALUE_WIDTH-1:0];
    negative  = bits[VALUE_WIDTH-1];
    magnitude = negative ? (~bits + 1'b1) : bits;
    rest      = magnitude;
    count     = 0;
    do begin
      digit[count] = int'(rest % 10);
      rest         = rest / 10;
      count++;
    end while (rest != 0 && count < 23);
    if (negative) begin
      ch.code = ASCII_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int k = count - 1; k >= 0; k--) begin
      ch.code = ASCII_ZERO + CHAR_WIDTH'(digit[k]);
      ch.last = (k == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic logic signed [INPUT_WIDTH-1:0] random_number();
    longint power;
    longint v;
    case ($urandom_range(0, 3))
      0, 1: v = longint'($signed($urandom()));
      2: begin
        v = longint'($urandom_range(0, 999));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        power = 1;
        repeat ($urandom_range(0, 9)) power = power * 10;
        v = power + longint'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return INPUT_WIDTH'(v);
  endfunction

  function automatic void queue_number(logic signed [INPUT_WIDTH-1:0] value, bit drain_first,
                                       bit quiet);
    number_req_t item;
    item.value       = value;
    item.drain_first = drain_first;
    item.quiet       = quiet;
    number_q.push_back(item);
  endfunction

  always @(posedge clk_i) begin : number_driver
    number_req_t                   item;
    logic                          next_valid;
    logic signed [INPUT_WIDTH-1:0] next_value;
    next_valid = in_valid_i;
    next_value = value_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_text(value_i);
        requests_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (number_q.size() != 0 &&
                     !(number_q[0].drain_first && expected_chars.size() != 0)) begin
          item       = number_q.pop_front();
          next_valid = 1'b1;
          next_value = item.value;
          if (item.quiet) tail_phase = 1'b1;
          if ($urandom_range(0, 39) == 0) sender_noise = $urandom_range(0, 3);
          if (!tail_phase && sender_noise != 0 && $urandom_range(0, 3) < sender_noise) begin
            gap_left = $urandom_range(1, GAP_MAX);
          end
        end
      end
    end
    in_valid_i <= next_valid;
    value_i    <= next_value;
  end

  always @(posedge clk_i) begin : char_stall
    logic next_stall;
    next_stall = 1'b0;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (!hold_done && requests_taken >= HOLD_AT) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        next_stall = 1'b1;
      end else if (!tail_phase) begin
        if ($urandom_range(0, 199) == 0) receiver_noise = $urandom_range(0, 3);
        if (burst_left > 0) begin
          burst_left--;
          next_stall = 1'b1;
        end else if (receiver_noise != 0 && $urandom_range(0, 15) < receiver_noise) begin
          burst_left = $urandom_range(0, GAP_MAX - 1);
          next_stall = 1'b1;
        end
      end
    end
    out_stall_i <= next_stall;
  end

  always @(posedge clk_i) begin : char_monitor
    text_char_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_code %0d, last %0d", char_code_o, last_o);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (char_code_o !== want.code) begin
          $error("char_code: expected %0d, actual %0d", want.code, char_code_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic signed [INPUT_WIDTH-1:0] directed[$];
    int                            random_count;
    directed = '{0, 1, -1, 9, 10, -9, -10, 99, 100, -100, 2147483647, -2147483648,
                 -2147483647, 1000000000, 999999999, -1000000000, -999999999, 1234567890,
                 -123, 42, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_FFFF};
    foreach (directed[i]) queue_number(directed[i], 1'b0, 1'b0);
    random_count = TOTAL_ITEMS - directed.size();
    for (int i = 0; i < random_count; i++) begin
      queue_number(random_number(), (i == 0) || (i == random_count / 2),
                   i >= random_count - QUIET_ITEMS);
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (number_q.size() != 0 || in_valid_i || expected_chars.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_chars.size() != 0) begin
      $error("%0d expected characters never arrived", expected_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
+incdir+rtl/core
rtl/core/sidc_pkg.sv
rtl/core/sidc_bin2bcd.sv
rtl/core/signed_int_to_decimal_ascii.sv
rtl/core/sidc_checker.sv
sim/signed_int_to_decimal_ascii_tb.sv
